// ===== rtl/core/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest path engine package
// Opcodes, status codes, graph sizes and result fields shared by the engine.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int NODE_COUNT  = 32;
    localparam int WEIGHT_BITS = 8;
    localparam int NODE_BITS   = 5;
    localparam int DIST_BITS   = 13;
    localparam int DIST_MAX    = 8191;

    typedef enum logic [1:0] {
        OP_ADD_EDGE    = 2'd0,
        OP_REMOVE_EDGE = 2'd1,
        OP_REMOVE_NODE = 2'd2,
        OP_QUERY       = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_SAME_NODE   = 3'd0,
        ST_DST_ISOLATE = 3'd1,
        ST_SRC_ISOLATE = 3'd2,
        ST_FOUND       = 3'd3,
        ST_UNREACHABLE = 3'd4
    } status_t;

    // Time fields of one result, derived from a saturated distance.
    typedef struct packed {
        logic [7:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds_part;
    } travel_time_t;

endpackage

// ===== rtl/core/shortest_path_engine_top.sv =====
// ----------------------------------------------------------------------------
// Shortest path engine
// Undirected weighted graph in an adjacency memory, with route queries.
// ----------------------------------------------------------------------------
// A query runs the isolation checks, the extraction scans and the relaxation
// sweeps, then the travel time conversion, then emits the results, which
// m_tready can hold. Its duration is set by the single adjacency memory port,
// which is read once per node in each relaxation sweep, and by the scan of
// every node in each extraction. Remove node sweeps 2*N memory writes. After
// reset the adjacency memory is cleared entry by entry, during which s_tready
// stays low.
module shortest_path_engine_top
    import spe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    // node_a[4:0], node_b[9:5], edge_weight[17:10], zero fill
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0]
    output logic [2:0]  m_tuser,
    // total_distance[12:0], hours[20:13], minutes[26:21], seconds_part[32:27],
    // path_node[37:33], zero fill
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    localparam int NB    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int AB    = 2 * NB;
    localparam int DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int ENTW  = WEIGHT_BITS + 1;
    localparam int CB    = NB + 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WAIT, S_ADD_WR1, S_ADD_WR2, S_REM_WR2,
        S_RMN, S_ISO_B, S_ISO_A, S_INIT, S_EXTRACT, S_RELAX, S_RELAX_WAIT,
        S_TRACE, S_TIME, S_TIME_WAIT, S_EMIT
    } state_t;

    state_t                state_reg;
    logic [ENTW-1:0]       adj_mem [DEPTH];
    logic [ENTW-1:0]       rd_data_reg;
    logic                  mem_we;
    logic [AB-1:0]         mem_addr;
    logic [ENTW-1:0]       mem_wdata;

    logic [DIST_BITS-1:0]  dist_reg  [NODE_COUNT];
    logic [NB-1:0]         pred_reg  [NODE_COUNT];
    logic [NB-1:0]         path_reg  [NODE_COUNT];
    logic [NODE_COUNT-1:0] visited_reg, reached_reg;

    logic [AB:0]           clr_reg;
    logic [CB-1:0]         idx_reg;
    logic [1:0]            op_reg;
    logic [4:0]            a_reg, b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic                  found_reg, rd_pend_reg;
    logic [NB-1:0]         u_reg;
    logic [DIST_BITS-1:0]  umin_reg;
    logic [NB-1:0]         node_reg;
    logic [CB-1:0]         len_reg, k_reg;
    logic [2:0]            status_reg;
    logic [DIST_BITS-1:0]  tot_reg;
    logic [4:0]            pn_reg;
    logic                  last_reg, mvalid_reg;
    logic [39:0]           m_data_reg;
    logic [2:0]            m_user_reg;
    travel_time_t          time_reg;

    logic                  a_ok, b_ok;
    logic [NB-1:0]         idx;
    logic [DIST_BITS:0]    nd_sum;
    logic [DIST_BITS-1:0]  nd;
    logic                  tc_start, tc_done;
    travel_time_t          tc_time;
    logic                  emit_fire, emit_last;
    logic [4:0]            emit_node;

    assign idx    = idx_reg[NB-1:0];
    assign a_ok   = ({1'b0, a_reg} < 6'(NODE_COUNT));
    assign b_ok   = ({1'b0, b_reg} < 6'(NODE_COUNT));
    assign nd_sum = {1'b0, dist_reg[u_reg]}
                  + (DIST_BITS + 1)'(rd_data_reg[WEIGHT_BITS-1:0]);
    // Saturated distances keep the order of the sums that the engine compares.
    assign nd     = nd_sum[DIST_BITS] ? DIST_BITS'(DIST_MAX) : nd_sum[DIST_BITS-1:0];

    // The output register lets the next item start while a result waits.
    assign emit_fire = (state_reg == S_EMIT) && (!mvalid_reg || m_tready);
    assign emit_last = (len_reg == CB'(1)) || (k_reg == CB'(31));
    assign emit_node = (status_reg == ST_FOUND) ? 5'(path_reg[NB'(len_reg - 1'b1)])
                                                : pn_reg;

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg[AB-1:0];
            end
            S_ADD_RD:  mem_addr = {a_reg[NB-1:0], b_reg[NB-1:0]};
            S_ADD_WR1, S_ADD_WR2, S_REM_WR2: begin
                mem_we = 1'b1;
                if (state_reg == S_ADD_WR2) begin
                    mem_addr = {b_reg[NB-1:0], a_reg[NB-1:0]};
                end else begin
                    mem_addr = {a_reg[NB-1:0], b_reg[NB-1:0]};
                end
                if (op_reg == OP_ADD_EDGE) begin
                    mem_wdata = {1'b1, w_reg};
                end
                if (state_reg == S_REM_WR2) begin
                    mem_addr = {b_reg[NB-1:0], a_reg[NB-1:0]};
                end
            end
            S_RMN: begin
                mem_we   = 1'b1;
                mem_addr = idx_reg[NB] ? {idx, a_reg[NB-1:0]} : {a_reg[NB-1:0], idx};
            end
            S_ISO_B:  mem_addr = {b_reg[NB-1:0], idx};
            S_ISO_A:  mem_addr = {a_reg[NB-1:0], idx};
            S_RELAX:  mem_addr = {u_reg, idx};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            adj_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= adj_mem[mem_addr];
    end

    assign tc_start = (state_reg == S_TIME);

    spe_time_conv u_time (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tc_start),
        .distance (tot_reg),
        .done     (tc_done),
        .time_out (tc_time)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            mvalid_reg  <= 1'b0;
            visited_reg <= '0;
            reached_reg <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            if (emit_fire) begin
                mvalid_reg <= 1'b1;
                m_user_reg <= status_reg;
                m_data_reg <= {2'd0, emit_node, time_reg.seconds_part, time_reg.minutes,
                               time_reg.hours, tot_reg};
                last_reg   <= emit_last;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AB + 1)'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg  <= s_tuser;
                        a_reg   <= s_tdata[4:0];
                        b_reg   <= s_tdata[9:5];
                        w_reg   <= s_tdata[10 +: WEIGHT_BITS];
                        idx_reg <= '0;
                        unique case (opcode_t'(s_tuser))
                            OP_ADD_EDGE:    state_reg <= S_ADD_RD;
                            OP_REMOVE_EDGE: state_reg <= S_ADD_WR1;
                            OP_REMOVE_NODE: state_reg <= S_RMN;
                            OP_QUERY:       state_reg <= S_ISO_B;
                            default:        state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_ADD_RD: begin
                    state_reg <= a_ok && b_ok ? S_ADD_WAIT : S_IDLE;
                end
                S_ADD_WAIT: begin
                    if (rd_data_reg[WEIGHT_BITS] && rd_data_reg[WEIGHT_BITS-1:0] < w_reg) begin
                        w_reg <= rd_data_reg[WEIGHT_BITS-1:0];
                    end
                    state_reg <= S_ADD_WR1;
                end
                S_ADD_WR1: begin
                    if (!(a_ok && b_ok)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= (op_reg == OP_ADD_EDGE) ? S_ADD_WR2 : S_REM_WR2;
                    end
                end
                S_ADD_WR2, S_REM_WR2: state_reg <= S_IDLE;
                S_RMN: begin
                    if (!a_ok) begin
                        state_reg <= S_IDLE;
                    end else begin
                        if (idx == NB'(NODE_COUNT - 1)) begin
                            idx_reg <= {~idx_reg[NB], {NB{1'b0}}};
                            if (idx_reg[NB]) state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_ISO_B, S_ISO_A: begin
                    // One read per cycle; data of the previous read is checked.
                    if (idx_reg == CB'(NODE_COUNT)) begin
                        rd_pend_reg <= 1'b0;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        tot_reg     <= '0;
                        len_reg     <= CB'(1);
                        k_reg       <= '0;
                        if (a_reg == b_reg) begin
                            status_reg <= ST_SAME_NODE;
                            pn_reg     <= a_reg;
                            state_reg  <= S_TIME;
                        end else begin
                            pn_reg <= '0;
                            if (state_reg == S_ISO_B) begin
                                if (!b_ok || !(found_reg ||
                                        (rd_pend_reg && rd_data_reg[WEIGHT_BITS]))) begin
                                    status_reg <= ST_DST_ISOLATE;
                                    state_reg  <= S_TIME;
                                end else begin
                                    state_reg <= S_ISO_A;
                                end
                            end else if (!a_ok || !(found_reg ||
                                    (rd_pend_reg && rd_data_reg[WEIGHT_BITS]))) begin
                                status_reg <= ST_SRC_ISOLATE;
                                state_reg  <= S_TIME;
                            end else begin
                                state_reg <= S_INIT;
                            end
                        end
                    end else begin
                        rd_pend_reg <= 1'b1;
                        if (rd_pend_reg && rd_data_reg[WEIGHT_BITS]) begin
                            found_reg <= 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_INIT: begin
                    visited_reg <= '0;
                    reached_reg <= NODE_COUNT'(1) << a_reg[NB-1:0];
                    dist_reg[a_reg[NB-1:0]] <= '0;
                    pred_reg[a_reg[NB-1:0]] <= a_reg[NB-1:0];
                    found_reg <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= S_EXTRACT;
                end
                S_EXTRACT: begin
                    if (idx_reg == CB'(NODE_COUNT)) begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        if (found_reg) begin
                            visited_reg[u_reg] <= 1'b1;
                            state_reg <= S_RELAX;
                        end else if (b_ok && reached_reg[b_reg[NB-1:0]]) begin
                            status_reg <= ST_FOUND;
                            tot_reg    <= dist_reg[b_reg[NB-1:0]];
                            node_reg   <= b_reg[NB-1:0];
                            len_reg    <= '0;
                            state_reg  <= S_TRACE;
                        end else begin
                            status_reg <= ST_UNREACHABLE;
                            state_reg  <= S_TIME;
                        end
                    end else begin
                        if (reached_reg[idx] && !visited_reg[idx] &&
                                (!found_reg || dist_reg[idx] < umin_reg)) begin
                            found_reg <= 1'b1;
                            u_reg     <= idx;
                            umin_reg  <= dist_reg[idx];
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_RELAX: begin
                    // Read at idx issued; evaluated next cycle.
                    state_reg <= S_RELAX_WAIT;
                end
                S_RELAX_WAIT: begin
                    if (rd_data_reg[WEIGHT_BITS] && !visited_reg[idx] &&
                            (!reached_reg[idx] || nd <= dist_reg[idx])) begin
                        dist_reg[idx]    <= nd;
                        pred_reg[idx]    <= u_reg;
                        reached_reg[idx] <= 1'b1;
                    end
                    if (idx == NB'(NODE_COUNT - 1)) begin
                        idx_reg   <= '0;
                        state_reg <= S_EXTRACT;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RELAX;
                    end
                end
                S_TRACE: begin
                    path_reg[len_reg[NB-1:0]] <= node_reg;
                    len_reg  <= len_reg + 1'b1;
                    node_reg <= pred_reg[node_reg];
                    if (node_reg == a_reg[NB-1:0] || len_reg == CB'(NODE_COUNT - 1)) begin
                        state_reg <= S_TIME;
                    end
                end
                S_TIME: state_reg <= S_TIME_WAIT;
                S_TIME_WAIT: begin
                    if (tc_done) begin
                        time_reg  <= tc_time;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        len_reg <= len_reg - 1'b1;
                        k_reg   <= k_reg + 1'b1;
                        if (emit_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_EMIT) else $error("stray result");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable({m_tuser, m_tdata, m_tlast}))
        else $error("result changed");
    a_visited_reached: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXTRACT) |-> ((visited_reg & ~reached_reg) == '0))
        else $error("visited node not reached");

endmodule

// ===== rtl/core/spe_time_conv.sv =====
// ----------------------------------------------------------------------------
// Travel time converter
// Turns a distance into hours, minutes and seconds at 75 seconds per unit,
// by repeated subtraction of 3600 and then of 60.
// ----------------------------------------------------------------------------
module spe_time_conv
    import spe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIST_BITS-1:0] distance,
    output logic                 done,
    output travel_time_t         time_out
);

    typedef enum logic [1:0] {
        TC_IDLE,
        TC_HOURS,
        TC_MINUTES,
        TC_DONE
    } tc_state_t;

    localparam int SEC_BITS = 20;

    tc_state_t            state_reg;
    logic [SEC_BITS-1:0]  rem_reg;
    logic [8:0]           hours_reg;
    logic [5:0]           minutes_reg;
    logic [SEC_BITS-1:0]  product;

    // distance * 75 = distance * 64 + distance * 8 + distance * 2 + distance
    assign product = {1'b0, distance, 6'd0} + {4'd0, distance, 3'd0}
                   + {6'd0, distance, 1'd0} + {7'd0, distance};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TC_IDLE;
        end else begin
            unique case (state_reg)
                TC_IDLE: begin
                    if (start) begin
                        rem_reg     <= product;
                        hours_reg   <= '0;
                        minutes_reg <= '0;
                        state_reg   <= TC_HOURS;
                    end
                end
                TC_HOURS: begin
                    if (rem_reg >= SEC_BITS'(3600)) begin
                        rem_reg   <= rem_reg - SEC_BITS'(3600);
                        hours_reg <= hours_reg + 9'd1;
                    end else begin
                        state_reg <= TC_MINUTES;
                    end
                end
                TC_MINUTES: begin
                    if (rem_reg >= SEC_BITS'(60)) begin
                        rem_reg     <= rem_reg - SEC_BITS'(60);
                        minutes_reg <= minutes_reg + 6'd1;
                    end else begin
                        state_reg <= TC_DONE;
                    end
                end
                TC_DONE: state_reg <= TC_IDLE;
                default: state_reg <= TC_IDLE;
            endcase
        end
    end

    assign done                  = (state_reg == TC_DONE);
    assign time_out.hours        = (hours_reg > 9'd255) ? 8'd255 : hours_reg[7:0];
    assign time_out.minutes      = minutes_reg;
    assign time_out.seconds_part = rem_reg[5:0];

endmodule
